[rtl/sfr_pkg.sv]
// Shared types and constants for the stuffed frame receiver.
// No dependencies; imported by every module of the block.
package sfr_pkg;

	localparam logic [7:0] FLAG_BYTE   = 8'h7e;
	localparam logic [7:0] ESCAPE_BYTE = 8'h7d;
	localparam logic [7:0] ESC_MASK    = 8'h20;

	localparam logic [1:0] KIND_CMD  = 2'd0;
	localparam logic [1:0] KIND_ACK  = 2'd1;
	localparam logic [1:0] KIND_INFO = 2'd2;

	localparam logic [2:0] EV_PAYLOAD  = 3'd0;
	localparam logic [2:0] EV_CMD_OK   = 3'd1;
	localparam logic [2:0] EV_ACK_OK   = 3'd2;
	localparam logic [2:0] EV_INFO_OK  = 3'd3;
	localparam logic [2:0] EV_INFO_BAD = 3'd4;

	localparam logic [1:0] ACK_RR0  = 2'd0;
	localparam logic [1:0] ACK_RR1  = 2'd1;
	localparam logic [1:0] ACK_REJ0 = 2'd2;
	localparam logic [1:0] ACK_REJ1 = 2'd3;

	localparam logic [2:0] REG_EXPECT_ADDR = 3'd0;
	localparam logic [2:0] REG_EXPECT_CTRL = 3'd1;
	localparam logic [2:0] REG_FRAME_KIND  = 3'd2;
	localparam logic [2:0] REG_RR0         = 3'd3;
	localparam logic [2:0] REG_RR1         = 3'd4;
	localparam logic [2:0] REG_REJ0        = 3'd5;
	localparam logic [2:0] REG_REJ1        = 3'd6;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_FLAG = 3'd1,
		PH_ADDR = 3'd2,
		PH_CTRL = 3'd3,
		PH_DATA = 3'd4,
		PH_HDR  = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] expect_addr;
		logic [7:0] expect_ctrl;
		logic [1:0] frame_kind;
		logic [7:0] rr0_code;
		logic [7:0] rr1_code;
		logic [7:0] rej0_code;
		logic [7:0] rej1_code;
	} cfg_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] payload;
		logic [1:0] ack_kind;
	} result_t;

endpackage

[rtl/sfr_decode.sv]
// Frame state machine: header checks, destuffing and payload check.
// Depends on sfr_pkg; instantiated by stuffed_frame_receiver.
module sfr_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       line_byte,
	input  sfr_pkg::cfg_t    cfg,
	output logic             res_valid,
	output sfr_pkg::result_t res
);
	import sfr_pkg::*;

	phase_t     phase_q, phase_d;
	logic [1:0] ack_seen_q, ack_seen_d;
	logic [7:0] ctrl_seen_q, ctrl_seen_d;
	logic [7:0] held_q, held_d;
	logic       held_valid_q, held_valid_d;
	logic       esc_q, esc_d;
	logic [7:0] check_q, check_d;
	logic       is_flag;
	logic [7:0] data_byte;

	assign is_flag = (line_byte == FLAG_BYTE);

	always_comb begin
		phase_d      = phase_q;
		ack_seen_d   = ack_seen_q;
		ctrl_seen_d  = ctrl_seen_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		esc_d        = esc_q;
		check_d      = check_q;
		res_valid    = 1'b0;
		res          = '0;
		data_byte    = esc_q ? (line_byte ^ ESC_MASK) : line_byte;
		case (phase_q)
			PH_HUNT: begin
				if (is_flag) phase_d = PH_FLAG;
			end
			PH_FLAG: begin
				if (is_flag) phase_d = PH_FLAG;
				else if (line_byte == cfg.expect_addr) phase_d = PH_ADDR;
				else phase_d = PH_HUNT;
			end
			PH_ADDR: begin
				if (is_flag) begin
					phase_d = PH_FLAG;
				end else if (cfg.frame_kind == KIND_ACK) begin
					ctrl_seen_d = line_byte;
					phase_d     = PH_CTRL;
					if (line_byte == cfg.rr0_code) ack_seen_d = ACK_RR0;
					else if (line_byte == cfg.rr1_code) ack_seen_d = ACK_RR1;
					else if (line_byte == cfg.rej0_code) ack_seen_d = ACK_REJ0;
					else if (line_byte == cfg.rej1_code) ack_seen_d = ACK_REJ1;
					else phase_d = PH_HUNT;
				end else if (line_byte == cfg.expect_ctrl) begin
					ctrl_seen_d = line_byte;
					phase_d     = PH_CTRL;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_CTRL: begin
				if (is_flag) begin
					phase_d = PH_FLAG;
				end else if (line_byte == (cfg.expect_addr ^ ctrl_seen_q)) begin
					if (cfg.frame_kind == KIND_INFO) begin
						phase_d      = PH_DATA;
						held_d       = '0;
						held_valid_d = 1'b0;
						esc_d        = 1'b0;
						check_d      = '0;
					end else begin
						phase_d = PH_HDR;
					end
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_HDR: begin
				phase_d = PH_HUNT;
				if (is_flag) begin
					res_valid = 1'b1;
					if (cfg.frame_kind == KIND_ACK) begin
						res.event_res = EV_ACK_OK;
						res.ack_kind  = ack_seen_q;
					end else begin
						res.event_res = EV_CMD_OK;
					end
				end
			end
			PH_DATA: begin
				if (is_flag) begin
					phase_d       = PH_HUNT;
					held_valid_d  = 1'b0;
					esc_d         = 1'b0;
					res_valid     = 1'b1;
					res.event_res = (held_valid_q && !esc_q && held_q == check_q) ?
						EV_INFO_OK : EV_INFO_BAD;
				end else if (!esc_q && line_byte == ESCAPE_BYTE) begin
					esc_d = 1'b1;
				end else begin
					esc_d        = 1'b0;
					held_d       = data_byte;
					held_valid_d = 1'b1;
					if (held_valid_q) begin
						check_d       = check_q ^ held_q;
						res_valid     = 1'b1;
						res.event_res = EV_PAYLOAD;
						res.payload   = held_q;
					end
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			held_valid_q <= 1'b0;
			esc_q        <= 1'b0;
			ack_seen_q   <= '0;
			ctrl_seen_q  <= '0;
			held_q       <= '0;
			check_q      <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			held_valid_q <= held_valid_d;
			esc_q        <= esc_d;
			ack_seen_q   <= ack_seen_d;
			ctrl_seen_q  <= ctrl_seen_d;
			held_q       <= held_d;
			check_q      <= check_d;
		end
	end

endmodule

[rtl/stuffed_frame_receiver.sv]
// Top level of the stuffed frame receiver: config registers and output buffer.
// Depends on sfr_pkg and sfr_decode.
//
// Takes one line byte per clock cycle while in_stall is low. A byte updates
// the frame state at the edge that accepts it, and its result, if any, is
// registered at that edge. A two-entry output buffer sits in front of the
// result channel, so in_stall is a register output (it rises only when both
// entries are full) and never depends on out_stall in the same cycle.
// Payload bytes come out one byte late, since the last byte of a frame is
// its check byte. Configuration writes take effect at the next byte.
module stuffed_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] line_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] event_res,
	output logic [7:0] payload,
	output logic [1:0] ack_kind
);
	import sfr_pkg::*;

	cfg_t    cfg_q;
	logic    in_fire;
	logic    out_fire;
	logic    new_valid;
	result_t new_res;
	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expect_addr <= 8'd3;
			cfg_q.expect_ctrl <= 8'd0;
			cfg_q.frame_kind  <= KIND_CMD;
			cfg_q.rr0_code    <= 8'd5;
			cfg_q.rr1_code    <= 8'd133;
			cfg_q.rej0_code   <= 8'd1;
			cfg_q.rej1_code   <= 8'd129;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXPECT_ADDR: cfg_q.expect_addr <= cfg_data;
				REG_EXPECT_CTRL: cfg_q.expect_ctrl <= cfg_data;
				REG_FRAME_KIND:  cfg_q.frame_kind  <= cfg_data[1:0];
				REG_RR0:         cfg_q.rr0_code    <= cfg_data;
				REG_RR1:         cfg_q.rr1_code    <= cfg_data;
				REG_REJ0:        cfg_q.rej0_code   <= cfg_data;
				REG_REJ1:        cfg_q.rej1_code   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = skid_valid_q;
	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid_q && !out_stall;

	sfr_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (in_fire),
		.line_byte (line_byte),
		.cfg       (cfg_q),
		.res_valid (new_valid),
		.res       (new_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) skid_valid_q <= 1'b0;
		end else if (in_fire && new_valid) begin
			if (out_valid_q && !out_fire) skid_valid_q <= 1'b1;
			else out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) out_q <= skid_q;
		end else if (in_fire && new_valid) begin
			if (out_valid_q && !out_fire) skid_q <= new_res;
			else out_q <= new_res;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = out_q.event_res;
	assign payload   = out_q.payload;
	assign ack_kind  = out_q.ack_kind;

endmodule

[rtl/sfr_checker.sv]
// Port-level checks for the stuffed frame receiver, bound to the top level.
// Depends on sfr_pkg and stuffed_frame_receiver.
module sfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] event_res,
	input logic [7:0] payload,
	input logic [1:0] ack_kind
);
	import sfr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res) &&
			$stable(payload) && $stable(ack_kind))
		else $error("stalled result transaction changed");

	a_new_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall))
		else $error("result transaction without an input transaction");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_PAYLOAD |-> payload == 8'd0)
		else $error("payload nonzero on a frame report");

	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_ACK_OK |-> ack_kind == ACK_RR0)
		else $error("ack kind nonzero outside an ack report");

	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_res == EV_PAYLOAD || event_res == EV_CMD_OK ||
			event_res == EV_ACK_OK || event_res == EV_INFO_OK ||
			event_res == EV_INFO_BAD)
		else $error("undefined event code");

endmodule

bind stuffed_frame_receiver sfr_checker u_sfr_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for stuffed_frame_receiver: directed frames, then random frame traffic.
// Depends on sfr_pkg and the stuffed_frame_receiver RTL; both handshakes idle and stall at random.
// Results are compared field by field against an in-bench frame decoder.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sfr_pkg::*;

	typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_LISTED} exp_src_t;
	typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [2:0] reg_idx;
		logic [7:0] value;
		exp_src_t   src;
		result_t    res;
	} dir_row_t;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int DIR_ROWS = 31;
	localparam int PHASES = 9;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] line_byte = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] event_res;
	logic [7:0] payload;
	logic [1:0] ack_kind;

	stuffed_frame_receiver u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.line_byte(line_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.payload(payload),
		.ack_kind(ack_kind)
	);

	// frame decoder state and register copy
	cfg_t       cfg = '{8'd3, 8'd0, KIND_CMD, 8'd5, 8'd133, 8'd1, 8'd129};
	phase_t     rx_phase = PH_HUNT;
	logic [1:0] ack_code = '0;
	logic [7:0] hdr_ctrl = '0;
	logic [7:0] hold_byte = '0;
	logic [7:0] xor_sum = '0;
	bit         hold_ok = 1'b0;
	bit         esc_armed = 1'b0;

	result_t    rx_expected[$];
	logic [7:0] frame_bytes[$];
	int         mismatch_count = 0;
	bit         idle_on = 1'b1;

	dir_row_t dir_table [DIR_ROWS] = '{
		'{ROW_BYTE, '0, 8'h00, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h7e, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h7e, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h03, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h00, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h03, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h7e, EXP_LISTED, '{EV_CMD_OK, 8'h00, ACK_RR0}},
		'{ROW_REG, REG_FRAME_KIND, 8'(KIND_ACK), EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h7e, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h03, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h7e, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h03, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h85, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h86, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h7e, EXP_LISTED, '{EV_ACK_OK, 8'h00, ACK_RR1}},
		'{ROW_REG, REG_FRAME_KIND, 8'(KIND_INFO), EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h7e, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h03, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h00, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h03, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'hff, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h7d, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h5e, EXP_PREDICT, '0},
		'{ROW_BYTE, '0, 8'h81, EXP_PREDICT, '0},
		'{ROW_BYTE, '0, 8'h7e, EXP_LISTED, '{EV_INFO_OK, 8'h00, ACK_RR0}},
		'{ROW_BYTE, '0, 8'h7e, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h03, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h00, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h03, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h7d, EXP_NONE, '0},
		'{ROW_BYTE, '0, 8'h7e, EXP_LISTED, '{EV_INFO_BAD, 8'h00, ACK_RR0}}
	};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic bit rx_decode(input logic [7:0] b, output result_t r);
		logic [7:0] d;
		bit         is_flag;
		r = '0;
		is_flag = (b == FLAG_BYTE);
		case (rx_phase)
			PH_HUNT: begin
				if (is_flag)
					rx_phase = PH_FLAG;
				return 1'b0;
			end
			PH_FLAG: begin
				if (is_flag)
					rx_phase = PH_FLAG;
				else if (b == cfg.expect_addr)
					rx_phase = PH_ADDR;
				else
					rx_phase = PH_HUNT;
				return 1'b0;
			end
			PH_ADDR: begin
				if (is_flag) begin
					rx_phase = PH_FLAG;
					return 1'b0;
				end
				if (cfg.frame_kind == KIND_ACK) begin
					if (b == cfg.rr0_code)
						ack_code = ACK_RR0;
					else if (b == cfg.rr1_code)
						ack_code = ACK_RR1;
					else if (b == cfg.rej0_code)
						ack_code = ACK_REJ0;
					else if (b == cfg.rej1_code)
						ack_code = ACK_REJ1;
					else begin
						rx_phase = PH_HUNT;
						return 1'b0;
					end
					hdr_ctrl = b;
					rx_phase = PH_CTRL;
				end else if (b == cfg.expect_ctrl) begin
					hdr_ctrl = b;
					rx_phase = PH_CTRL;
				end else begin
					rx_phase = PH_HUNT;
				end
				return 1'b0;
			end
			PH_CTRL: begin
				if (is_flag) begin
					rx_phase = PH_FLAG;
					return 1'b0;
				end
				if (b == (cfg.expect_addr ^ hdr_ctrl)) begin
					if (cfg.frame_kind == KIND_INFO) begin
						rx_phase = PH_DATA;
						hold_byte = '0;
						hold_ok = 1'b0;
						esc_armed = 1'b0;
						xor_sum = '0;
					end else begin
						rx_phase = PH_HDR;
					end
				end else begin
					rx_phase = PH_HUNT;
				end
				return 1'b0;
			end
			PH_HDR: begin
				rx_phase = PH_HUNT;
				if (!is_flag)
					return 1'b0;
				if (cfg.frame_kind == KIND_ACK)
					r = '{EV_ACK_OK, 8'h00, ack_code};
				else
					r.event_res = EV_CMD_OK;
				return 1'b1;
			end
			PH_DATA: begin
				if (is_flag) begin
					r.event_res = (hold_ok && !esc_armed && hold_byte == xor_sum) ?
						EV_INFO_OK : EV_INFO_BAD;
					rx_phase = PH_HUNT;
					hold_ok = 1'b0;
					esc_armed = 1'b0;
					return 1'b1;
				end
				if (esc_armed) begin
					d = b ^ ESC_MASK;
					esc_armed = 1'b0;
				end else if (b == ESCAPE_BYTE) begin
					esc_armed = 1'b1;
					return 1'b0;
				end else begin
					d = b;
				end
				if (hold_ok) begin
					r.event_res = EV_PAYLOAD;
					r.payload = hold_byte;
					xor_sum = xor_sum ^ hold_byte;
					hold_byte = d;
					return 1'b1;
				end
				hold_byte = d;
				hold_ok = 1'b1;
				return 1'b0;
			end
			default: begin
				rx_phase = PH_HUNT;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic int pick_wait();
		return idle_on ? $urandom_range(0, 7) : 0;
	endfunction

	function automatic bit one_in(input int n);
		return $urandom_range(0, n - 1) == 0;
	endfunction

	function automatic logic [7:0] data_byte();
		if (one_in(5))
			return one_in(2) ? FLAG_BYTE : ESCAPE_BYTE;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void push_stuffed(input logic [7:0] v);
		if (v == FLAG_BYTE || v == ESCAPE_BYTE || (one_in(10) && v != (FLAG_BYTE ^ ESC_MASK))) begin
			frame_bytes.push_back(ESCAPE_BYTE);
			frame_bytes.push_back(v ^ ESC_MASK);
		end else begin
			frame_bytes.push_back(v);
		end
	endfunction

	// mostly well-formed frames for the current setting, some broken ones and line noise
	function automatic void build_frame();
		logic [7:0] a;
		logic [7:0] c;
		logic [7:0] x;
		logic [7:0] v;
		int         len;
		frame_bytes.delete();
		if (one_in(12)) begin
			repeat ($urandom_range(1, 6))
				frame_bytes.push_back(data_byte());
			return;
		end
		frame_bytes.push_back(FLAG_BYTE);
		if (one_in(5))
			frame_bytes.push_back(FLAG_BYTE);
		a = one_in(10) ? 8'($urandom_range(0, 255)) : cfg.expect_addr;
		if (cfg.frame_kind == KIND_ACK) begin
			case ($urandom_range(0, 3))
				0: c = cfg.rr0_code;
				1: c = cfg.rr1_code;
				2: c = cfg.rej0_code;
				default: c = cfg.rej1_code;
			endcase
		end else begin
			c = cfg.expect_ctrl;
		end
		if (one_in(10))
			c = 8'($urandom_range(0, 255));
		frame_bytes.push_back(a);
		frame_bytes.push_back(c);
		frame_bytes.push_back(one_in(10) ? 8'($urandom_range(0, 255)) : a ^ c);
		if (cfg.frame_kind == KIND_INFO || one_in(20)) begin
			len = one_in(20) ? 40 : $urandom_range(0, 9);
			x = '0;
			for (int i = 0; i < len; i++) begin
				v = data_byte();
				x = x ^ v;
				push_stuffed(v);
			end
			if (!one_in(10))
				push_stuffed(one_in(7) ? 8'($urandom_range(0, 255)) : x);
			if (one_in(20))
				frame_bytes.push_back(ESCAPE_BYTE);
		end
		frame_bytes.push_back(one_in(10) ? 8'($urandom_range(0, 255)) : FLAG_BYTE);
	endfunction

	task automatic send_byte(input logic [7:0] b, input exp_src_t src, input result_t listed);
		result_t r;
		bit      got;
		repeat (pick_wait()) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		line_byte <= b;
		do @(posedge clk); while (in_stall);
		got = rx_decode(b, r);
		case (src)
			EXP_PREDICT: if (got) rx_expected.push_back(r);
			EXP_LISTED: rx_expected.push_back(listed);
			default: ;
		endcase
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_EXPECT_ADDR: cfg.expect_addr = val;
			REG_EXPECT_CTRL: cfg.expect_ctrl = val;
			REG_FRAME_KIND: cfg.frame_kind = val[1:0];
			REG_RR0: cfg.rr0_code = val;
			REG_RR1: cfg.rr1_code = val;
			REG_REJ0: cfg.rej0_code = val;
			REG_REJ1: cfg.rej1_code = val;
			default: ;
		endcase
	endtask

	// input idle, then every expected transaction out
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (rx_expected.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_phase_config(input int p);
		logic [7:0] a;
		logic [7:0] c;
		logic [7:0] k0;
		logic [7:0] k1;
		logic [7:0] k2;
		logic [7:0] k3;
		logic [1:0] kd;
		a = 8'($urandom_range(0, 255));
		c = 8'($urandom_range(0, 255));
		k0 = 8'($urandom_range(0, 255));
		k1 = 8'($urandom_range(0, 255));
		k2 = 8'($urandom_range(0, 255));
		k3 = 8'($urandom_range(0, 255));
		kd = KIND_INFO;
		case (p)
			0: begin
				a = 8'h00;
				c = 8'hff;
				kd = KIND_CMD;
			end
			1: begin
				a = 8'hff;
				kd = KIND_ACK;
			end
			3: begin
				kd = KIND_ACK;
				k2 = k1;
				k3 = k0;
			end
			4: kd = KIND_SPARE;
			5: begin
				a = 8'hff;
				c = 8'h00;
			end
			6: begin
				kd = KIND_ACK;
				k0 = 8'h00;
				k1 = 8'hff;
				k2 = FLAG_BYTE;
			end
			7: begin
				a = FLAG_BYTE;
				kd = KIND_CMD;
			end
			8: a = ESCAPE_BYTE;
			default: ;
		endcase
		write_reg(REG_EXPECT_ADDR, a);
		write_reg(REG_EXPECT_CTRL, c);
		write_reg(REG_FRAME_KIND, 8'(kd));
		write_reg(REG_RR0, k0);
		write_reg(REG_RR1, k1);
		write_reg(REG_REJ0, k2);
		write_reg(REG_REJ1, k3);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (rx_expected.size() == 0) begin
				$error("unexpected transaction: event_res %0d payload %02h ack_kind %0d",
					event_res, payload, ack_kind);
				mismatch_count++;
			end else begin
				want = rx_expected.pop_front();
				if (event_res !== want.event_res) begin
					$error("event_res: expected %0d, got %0d", want.event_res, event_res);
					mismatch_count++;
				end
				if (payload !== want.payload) begin
					$error("payload: expected %02h, got %02h", want.payload, payload);
					mismatch_count++;
				end
				if (ack_kind !== want.ack_kind) begin
					$error("ack_kind: expected %0d, got %0d", want.ack_kind, ack_kind);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			repeat (pick_wait()) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int quota;
		int sent;
		int cut;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_table[i]) begin
			if (dir_table[i].kind == ROW_REG) begin
				settle();
				write_reg(dir_table[i].reg_idx, dir_table[i].value);
			end else begin
				send_byte(dir_table[i].value, dir_table[i].src, dir_table[i].res);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			load_phase_config(p);
			idle_on = (p % 3 != 1);
			quota = (p == 7) ? 30 : 100;
			sent = 0;
			while (sent < quota) begin
				build_frame();
				foreach (frame_bytes[j])
					send_byte(frame_bytes[j], EXP_PREDICT, '0);
				sent += frame_bytes.size();
			end
			// sometimes send a frame cut at a random point so the next setting can apply mid-frame
			if (one_in(2)) begin
				build_frame();
				cut = $urandom_range(1, frame_bytes.size());
				for (int j = 0; j < cut; j++)
					send_byte(frame_bytes[j], EXP_PREDICT, '0);
			end
		end

		settle();
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
